FILE: src/dhrs_pkg.sv
package dhrs_pkg;

    // Default width of the two watchdog tick counters.
    localparam int DEFAULT_COUNT_WIDTH = 16;

    // Widths of the configuration registers and of the write port.
    localparam int LIMIT_WIDTH     = 16;
    localparam int EDGE_WIDTH      = 4;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIO_TICK_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOST_TICK_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIO_EDGES_NEEDED = 2'd2;

    // Configuration reset values.
    localparam logic [LIMIT_WIDTH-1:0] RESET_RADIO_TICK_LIMIT   = 16'd100;
    localparam logic [LIMIT_WIDTH-1:0] RESET_HOST_TICK_LIMIT    = 16'd5000;
    localparam logic [EDGE_WIDTH-1:0]  RESET_RADIO_EDGES_NEEDED = 4'd10;

    // Input item kinds. Code 3 is unused and leaves the state alone.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RADIO = 2'd1,
        OP_HOST  = 2'd2
    } opcode_t;

    // Reset causes reported with each result.
    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_HOST  = 2'd1,
        CAUSE_RADIO = 2'd2
    } cause_t;

    // Input transaction payload.
    typedef struct packed {
        opcode_t opcode;
        logic    enable_level;
        logic    pin_level;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic   reset_fire;
        cause_t reset_cause;
        logic   radio_led;
        logic   host_led;
    } out_item_t;

    // Configuration handed to the update logic.
    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] radio_tick_limit;
        logic [LIMIT_WIDTH-1:0] host_tick_limit;
        logic [EDGE_WIDTH-1:0]  radio_edges_needed;
    } cfg_t;

endpackage

FILE: src/dual_heartbeat_reset_supervisor_top.sv
// Dual heartbeat reset supervisor. Each input transaction is a timer tick, a
// radio pin event or a host pin event, and each produces exactly one output
// transaction carrying the reset pulse start, the last reset cause and the two
// LED levels. The block sustains one transaction per clock while out_ready
// holds: an item is held in an input register, updated against the supervisor
// state and written to the output register. The input register also absorbs
// one item while the output register is stalled. The reset pulse length and
// the bootloader line belong to an external pulse stretcher. Configuration
// writes must be made by the user while idle; the block does not enforce it.
module dual_heartbeat_reset_supervisor_top
    import dhrs_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_item_t                   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_item_t                  out_data,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      out_free;
    logic      advance;
    out_item_t result;

    // Handshake control for the two register stages.
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radio_tick_limit   <= RESET_RADIO_TICK_LIMIT;
            cfg_reg.host_tick_limit    <= RESET_HOST_TICK_LIMIT;
            cfg_reg.radio_edges_needed <= RESET_RADIO_EDGES_NEEDED;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RADIO_TICK_LIMIT:
                begin
                    cfg_reg.radio_tick_limit <= cfg_data[LIMIT_WIDTH-1:0];
                end
                CFG_HOST_TICK_LIMIT:
                begin
                    cfg_reg.host_tick_limit <= cfg_data[LIMIT_WIDTH-1:0];
                end
                CFG_RADIO_EDGES_NEEDED:
                begin
                    cfg_reg.radio_edges_needed <= cfg_data[EDGE_WIDTH-1:0];
                end
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    // State update for the item in the input register.
    dhrs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Output register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: src/dhrs_core.sv
module dhrs_core
    import dhrs_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    // Comparison width covers both the counters and the 16-bit limits.
    localparam int CMP_W = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
    localparam logic [EDGE_WIDTH-1:0] EDGE_MAX = {EDGE_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] radio_count_reg, radio_count_next;
    logic [COUNT_WIDTH-1:0] host_count_reg, host_count_next;
    logic [EDGE_WIDTH-1:0]  radio_edge_count_reg, radio_edge_count_next;
    logic                   radio_pending_reg, radio_pending_next;
    logic                   radio_last_level_reg, radio_last_level_next;
    logic                   host_last_level_reg, host_last_level_next;
    cause_t                 last_cause_reg, last_cause_next;
    logic                   radio_led_reg, radio_led_next;
    logic                   host_led_reg, host_led_next;
    logic                   fire;
    logic                   radio_due;
    logic                   host_due;

    // Watchdog conditions, evaluated on the current state.
    assign radio_due = (CMP_W'(radio_count_reg) >= CMP_W'(cfg.radio_tick_limit))
                       && !radio_pending_reg
                       && (radio_edge_count_reg > cfg.radio_edges_needed);
    assign host_due  = CMP_W'(host_count_reg) >= CMP_W'(cfg.host_tick_limit);

    // Next state for one item.
    always_comb
    begin
        radio_count_next      = radio_count_reg;
        host_count_next       = host_count_reg;
        radio_edge_count_next = radio_edge_count_reg;
        radio_pending_next    = radio_pending_reg;
        radio_last_level_next = radio_last_level_reg;
        host_last_level_next  = host_last_level_reg;
        last_cause_next       = last_cause_reg;
        radio_led_next        = radio_led_reg;
        host_led_next         = host_led_reg;
        fire                  = 1'b0;

        unique case (item.opcode)
            OP_TICK:
            begin
                if (item.enable_level)
                begin
                    if (radio_due)
                    begin
                        radio_pending_next = 1'b1;
                        last_cause_next    = CAUSE_RADIO;
                        fire               = 1'b1;
                        radio_count_next   = '0;
                        host_count_next    = '0;
                    end
                    else if (host_due)
                    begin
                        last_cause_next  = CAUSE_HOST;
                        fire             = 1'b1;
                        radio_count_next = '0;
                        host_count_next  = '0;
                    end
                    // Counting stops while a radio reset is pending; counts saturate.
                    if (!radio_pending_next)
                    begin
                        if (radio_count_next != {COUNT_WIDTH{1'b1}})
                        begin
                            radio_count_next = radio_count_next + 1'b1;
                        end
                        if (host_count_next != {COUNT_WIDTH{1'b1}})
                        begin
                            host_count_next = host_count_next + 1'b1;
                        end
                    end
                end
            end
            OP_RADIO:
            begin
                // Every radio event counts, to one above the threshold, at most 15.
                if ((radio_edge_count_reg <= cfg.radio_edges_needed)
                    && (radio_edge_count_reg != EDGE_MAX))
                begin
                    radio_edge_count_next = radio_edge_count_reg + 1'b1;
                end
                if (item.pin_level != radio_last_level_reg)
                begin
                    radio_last_level_next = item.pin_level;
                    radio_led_next        = item.pin_level;
                    radio_count_next      = '0;
                    radio_pending_next    = 1'b0;
                end
            end
            OP_HOST:
            begin
                if (item.pin_level != host_last_level_reg)
                begin
                    host_last_level_next = item.pin_level;
                    host_led_next        = !item.pin_level;
                    host_count_next      = '0;
                end
            end
            default:
            begin
                // Unused opcode: state unchanged.
            end
        endcase
    end

    // Result reflects the state after this item.
    assign result.reset_fire  = fire;
    assign result.reset_cause = last_cause_next;
    assign result.radio_led   = radio_led_next;
    assign result.host_led    = host_led_next;

    // Supervisor state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radio_count_reg      <= '0;
            host_count_reg       <= '0;
            radio_edge_count_reg <= '0;
            radio_pending_reg    <= 1'b0;
            radio_last_level_reg <= 1'b0;
            host_last_level_reg  <= 1'b0;
            last_cause_reg       <= CAUSE_NONE;
            radio_led_reg        <= 1'b0;
            host_led_reg         <= 1'b0;
        end
        else if (step)
        begin
            radio_count_reg      <= radio_count_next;
            host_count_reg       <= host_count_next;
            radio_edge_count_reg <= radio_edge_count_next;
            radio_pending_reg    <= radio_pending_next;
            radio_last_level_reg <= radio_last_level_next;
            host_last_level_reg  <= host_last_level_next;
            last_cause_reg       <= last_cause_next;
            radio_led_reg        <= radio_led_next;
            host_led_reg         <= host_led_next;
        end
    end

endmodule

FILE: src/dhrs_checker.sv
module dhrs_checker
    import dhrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_ready,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    // A stalled output transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

    // The input side only stalls behind a waiting output transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no output transaction waiting");

    // A reset pulse always reports a cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reset_fire |-> out_data.reset_cause != CAUSE_NONE)
    else $error("reset pulse reported without a cause");

    // Once a cause is reported, later transactions never report none.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) && $past(rst_n)
        && $past(out_data.reset_cause) != CAUSE_NONE
        |-> out_data.reset_cause != CAUSE_NONE)
    else $error("reset cause returned to none");

endmodule

bind dual_heartbeat_reset_supervisor_top dhrs_checker u_dhrs_checker (.*);

FILE: test/dual_heartbeat_reset_supervisor_top_test.sv
`timescale 1ns / 1ps

module dual_heartbeat_reset_supervisor_top_test;
    import dhrs_pkg::*;

    localparam int CW = DEFAULT_COUNT_WIDTH;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 136;
    localparam int QUIET_TICKS = 20;
    localparam int HOST_KICK_EVERY = 8;
    localparam int TIMEOUT_NS = 40_000_000;
    localparam int MAX_REPORTS = 10;

    // The unused opcode leaves the supervisor state alone.
    localparam opcode_t OP_UNUSED = opcode_t'(2'b11);

    // One row of the directed table: a stimulus and, where it is obvious, its result.
    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    localparam out_item_t FROM_MODEL = '0;
    localparam int DIR_ROWS = 24;
    localparam int DIR_SPLIT = 10;

    // Rows before the split run with the reset register values, the rest with
    // short limits so that both watchdogs fire.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{OP_TICK,   1'b0, 1'b0}, 1'b1, '{1'b0, CAUSE_NONE,  1'b0, 1'b0}},
        '{'{OP_UNUSED, 1'b1, 1'b1}, 1'b1, '{1'b0, CAUSE_NONE,  1'b0, 1'b0}},
        '{'{OP_RADIO,  1'b0, 1'b1}, 1'b1, '{1'b0, CAUSE_NONE,  1'b1, 1'b0}},
        '{'{OP_RADIO,  1'b0, 1'b1}, 1'b1, '{1'b0, CAUSE_NONE,  1'b1, 1'b0}},
        '{'{OP_HOST,   1'b0, 1'b1}, 1'b1, '{1'b0, CAUSE_NONE,  1'b1, 1'b0}},
        '{'{OP_HOST,   1'b1, 1'b0}, 1'b1, '{1'b0, CAUSE_NONE,  1'b1, 1'b1}},
        '{'{OP_HOST,   1'b0, 1'b0}, 1'b1, '{1'b0, CAUSE_NONE,  1'b1, 1'b1}},
        '{'{OP_RADIO,  1'b1, 1'b0}, 1'b1, '{1'b0, CAUSE_NONE,  1'b0, 1'b1}},
        '{'{OP_TICK,   1'b1, 1'b1}, 1'b1, '{1'b0, CAUSE_NONE,  1'b0, 1'b1}},
        '{'{OP_TICK,   1'b0, 1'b0}, 1'b1, '{1'b0, CAUSE_NONE,  1'b0, 1'b1}},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b1, '{1'b1, CAUSE_RADIO, 1'b0, 1'b1}},
        '{'{OP_TICK,   1'b1, 1'b1}, 1'b0, FROM_MODEL},
        '{'{OP_RADIO,  1'b0, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_RADIO,  1'b1, 1'b1}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_RADIO,  1'b0, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_RADIO,  1'b0, 1'b1}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_RADIO,  1'b0, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b1, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_UNUSED, 1'b0, 1'b0}, 1'b0, FROM_MODEL},
        '{'{OP_TICK,   1'b0, 1'b1}, 1'b0, FROM_MODEL}
    };

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    in_item_t                   in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_item_t                  out_data;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    // Shadow copy of the supervisor registers and state.
    logic [LIMIT_WIDTH-1:0] radio_limit = RESET_RADIO_TICK_LIMIT;
    logic [LIMIT_WIDTH-1:0] host_limit = RESET_HOST_TICK_LIMIT;
    logic [EDGE_WIDTH-1:0]  edges_needed = RESET_RADIO_EDGES_NEEDED;
    logic [CW-1:0]          radio_cnt = '0;
    logic [CW-1:0]          host_cnt = '0;
    logic [3:0]             edge_cnt = '0;
    logic                   radio_pend = 1'b0;
    logic                   radio_lvl = 1'b0;
    logic                   host_lvl = 1'b0;
    cause_t                 cause = CAUSE_NONE;
    logic                   radio_led = 1'b0;
    logic                   host_led = 1'b0;

    out_item_t status_q[$];
    bit        idling = 1'b1;
    int        errors = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        settings_used = 1;
    int        radio_fires = 0;
    int        host_fires = 0;
    int        out_stall = 0;

    dual_heartbeat_reset_supervisor_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one item to the shadow state and returns the status it reports.
    function automatic out_item_t advance_supervisor(input in_item_t it);
        out_item_t res;
        logic      fire;
        fire = 1'b0;
        case (it.opcode)
            OP_TICK:
            begin
                if (it.enable_level)
                begin
                    if (radio_cnt >= radio_limit && !radio_pend && edge_cnt > edges_needed)
                    begin
                        radio_pend = 1'b1;
                        cause = CAUSE_RADIO;
                        fire = 1'b1;
                        radio_cnt = '0;
                        host_cnt = '0;
                    end
                    else if (host_cnt >= host_limit)
                    begin
                        cause = CAUSE_HOST;
                        fire = 1'b1;
                        radio_cnt = '0;
                        host_cnt = '0;
                    end
                    // Counting pauses while a radio reset is outstanding.
                    if (!radio_pend)
                    begin
                        if (radio_cnt != '1)
                            radio_cnt = radio_cnt + 1'b1;
                        if (host_cnt != '1)
                            host_cnt = host_cnt + 1'b1;
                    end
                end
            end
            OP_RADIO:
            begin
                if (edge_cnt <= edges_needed && edge_cnt < 4'd15)
                    edge_cnt = edge_cnt + 1'b1;
                if (it.pin_level != radio_lvl)
                begin
                    radio_lvl = it.pin_level;
                    radio_led = it.pin_level;
                    radio_cnt = '0;
                    radio_pend = 1'b0;
                end
            end
            OP_HOST:
            begin
                if (it.pin_level != host_lvl)
                begin
                    host_lvl = it.pin_level;
                    host_led = ~it.pin_level;
                    host_cnt = '0;
                end
            end
            default:
            begin
            end
        endcase
        res.reset_fire = fire;
        res.reset_cause = cause;
        res.radio_led = radio_led;
        res.host_led = host_led;
        return res;
    endfunction

    // Mostly heartbeat toggles interleaved with enabled ticks, with some noise.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it.enable_level = 1'($urandom_range(0, 1));
        it.pin_level = 1'($urandom_range(0, 1));
        if (pick < 55)
        begin
            it.opcode = OP_TICK;
            it.enable_level = ($urandom_range(0, 9) != 0);
        end
        else if (pick < 75)
        begin
            it.opcode = OP_RADIO;
            if ($urandom_range(0, 9) < 7)
                it.pin_level = ~radio_lvl;
        end
        else if (pick < 95)
        begin
            it.opcode = OP_HOST;
            if ($urandom_range(0, 9) < 7)
                it.pin_level = ~host_lvl;
        end
        else
            it.opcode = OP_UNUSED;
        return it;
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Presents one input transaction and records its status once it is taken.
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_supervisor(it);
        status_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Occasionally leaves the input idle for a short burst.
    task automatic maybe_pause();
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_RADIO_TICK_LIMIT:   radio_limit = val[LIMIT_WIDTH-1:0];
            CFG_HOST_TICK_LIMIT:    host_limit = val[LIMIT_WIDTH-1:0];
            CFG_RADIO_EDGES_NEEDED: edges_needed = val[EDGE_WIDTH-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Waits for the block to drain, then loads all three registers.
    task automatic program_limits(input int radio_ticks, input int host_ticks, input int edges);
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        write_reg(CFG_RADIO_TICK_LIMIT, CFG_DATA_WIDTH'(radio_ticks));
        write_reg(CFG_HOST_TICK_LIMIT, CFG_DATA_WIDTH'(host_ticks));
        write_reg(CFG_RADIO_EDGES_NEEDED, CFG_DATA_WIDTH'(edges));
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Output side: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else if (idling && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            out_stall <= $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    // Compare every output transaction with the oldest predicted status.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
                note_failure($sformatf(
                    "unexpected output transaction fire=%b cause=%0d leds=%b%b",
                    out_data.reset_fire, out_data.reset_cause,
                    out_data.radio_led, out_data.host_led));
            else
            begin
                want = status_q.pop_front();
                results_seen++;
                if (want.reset_fire && want.reset_cause == CAUSE_RADIO)
                    radio_fires++;
                else if (want.reset_fire)
                    host_fires++;
                if (out_data.reset_fire !== want.reset_fire ||
                    out_data.reset_cause !== want.reset_cause ||
                    out_data.radio_led !== want.radio_led ||
                    out_data.host_led !== want.host_led)
                    note_failure($sformatf(
                        {"result %0d: expected fire=%b cause=%0d radio_led=%b host_led=%b,",
                         " got fire=%b cause=%0d radio_led=%b host_led=%b"},
                        results_seen, want.reset_fire, want.reset_cause, want.radio_led,
                        want.host_led, out_data.reset_fire, out_data.reset_cause,
                        out_data.radio_led, out_data.host_led));
            end
        end
    end

    // Main stimulus sequence.
    initial
    begin
        int       i;
        int       p;
        in_item_t it;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; the second part runs with short limits and zero edges needed.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_SPLIT)
                program_limits(2, 3, 0);
            send_item(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
            maybe_pause();
        end

        // Quiet radio line with the watchdog unarmed, so the radio count runs past
        // its limit. Host toggles keep the host watchdog quiet. Repeated-level radio
        // events then arm the watchdog without clearing the count, and the next tick
        // must fire.
        program_limits(8, 65535, 14);
        for (i = 0; i < QUIET_TICKS; i++)
        begin
            if (i % HOST_KICK_EVERY == HOST_KICK_EVERY - 1)
            begin
                it = '{OP_HOST, 1'b0, ~host_lvl};
                send_item(it, 1'b0, FROM_MODEL);
            end
            it = '{OP_TICK, 1'b1, 1'b0};
            send_item(it, 1'b0, FROM_MODEL);
            maybe_pause();
        end
        for (i = 0; i < 16; i++)
        begin
            it = '{OP_RADIO, 1'b1, radio_lvl};
            send_item(it, 1'b0, FROM_MODEL);
        end
        it = '{OP_TICK, 1'b1, 1'b0};
        send_item(it, 1'b0, FROM_MODEL);

        // Random phases over extreme and small register settings.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: program_limits(1, 1, 0);
                1: program_limits(65535, 65535, 15);
                2: program_limits(1, 65535, 14);
                3: program_limits(65535, 1, 0);
                default: program_limits($urandom_range(1, 16), $urandom_range(1, 40),
                                        $urandom_range(0, 15));
            endcase
            idling = (p != RANDOM_PHASES - 1);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_item(random_item(), 1'b0, FROM_MODEL);
                maybe_pause();
            end
        end

        // Drain and let the pipeline settle before the verdict.
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("Sent %0d input items over %0d register settings, with a %0d-tick quiet radio run.",
                 items_sent, settings_used, QUIET_TICKS);
        $display("Compared %0d results; %0d radio and %0d host reset pulses were predicted.",
                 results_seen, radio_fires, host_fires);
        if (errors == 0)
            $display("dual_heartbeat_reset_supervisor_top_test: done, clean");
        else
            $display("dual_heartbeat_reset_supervisor_top_test: done, errors");
        $finish;
    end

    // Watchdog on the run itself.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding.", status_q.size());
        $display("dual_heartbeat_reset_supervisor_top_test: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/dhrs_pkg.sv
src/dhrs_core.sv
src/dual_heartbeat_reset_supervisor_top.sv
src/dhrs_checker.sv
test/dual_heartbeat_reset_supervisor_top_test.sv
